>>> sv/brb_pkg.sv
// Shared types and constants for the byte ring buffer core.
// Used by brb_merge, byte_ring_buffer_core and the testbench; depends on nothing.
`default_nettype none

package brb_pkg;

  localparam int SLOTS_DEFAULT = 1024;
  localparam int LANES = 8;
  localparam int LANE_W = 3;
  localparam int MAX_BYTES_PER_ITEM = 8;
  localparam int COUNT_W = 10;
  localparam int BYTE_COUNT_W = 4;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_PEEK    = 3'd2,
    MODE_DISCARD = 3'd3,
    MODE_CLEAR   = 3'd4
  } mode_t;

  typedef logic [LANES-1:0][7:0] lane_bytes_t;

  typedef struct packed {
    logic                    ok;
    logic                    show;
    logic [BYTE_COUNT_W-1:0] count;
    logic [LANE_W-1:0]       rot;
    logic [COUNT_W-1:0]      stored;
    logic [COUNT_W-1:0]      free;
    logic                    empty;
    logic                    full;
  } meta_t;

endpackage

`default_nettype wire

>>> sv/brb_lane.sv
// One byte lane of the ring: a bank that holds every eighth slot.
// One write and one registered read per cycle; uses no package items.
`default_nettype none

module brb_lane #(
  parameter int ROWS = 128,
  parameter int ROW_W = 7
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [ROW_W-1:0] wr_row,
  input  wire logic [7:0]       wr_data,
  input  wire logic             rd_en,
  input  wire logic [ROW_W-1:0] rd_row,
  output logic      [7:0]       rd_data
);

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_row];
    end
  end

endmodule

`default_nettype wire

>>> sv/brb_merge.sv
// Merge stage: rotates the lane read bytes into order, masks by count and
// registers the result beat. Depends on brb_pkg.
`default_nettype none

module brb_merge (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 a_valid,
  input  wire brb_pkg::meta_t       a_meta,
  input  wire brb_pkg::lane_bytes_t lane_data,
  output logic                      take,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      ok,
  output logic [63:0]               read_bytes,
  output logic [brb_pkg::COUNT_W-1:0] stored_count,
  output logic [brb_pkg::COUNT_W-1:0] free_count,
  output logic                      is_empty,
  output logic                      is_full
);

  brb_pkg::lane_bytes_t merged;

  assign take = !out_valid || !out_stall;

  always_comb begin
    for (int i = 0; i < brb_pkg::LANES; i++) begin
      if (a_meta.show && (brb_pkg::BYTE_COUNT_W'(i) < a_meta.count)) begin
        merged[i] = lane_data[brb_pkg::LANE_W'(a_meta.rot + brb_pkg::LANE_W'(i))];
      end else begin
        merged[i] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= a_valid;
    end
    if (take && a_valid) begin
      ok           <= a_meta.ok;
      read_bytes   <= merged;
      stored_count <= a_meta.stored;
      free_count   <= a_meta.free;
      is_empty     <= a_meta.empty;
      is_full      <= a_meta.full;
    end
  end

endmodule

`default_nettype wire

>>> sv/byte_ring_buffer_core.sv
// Byte ring buffer core: eight interleaved byte lanes, pointer control, merge.
// Beats register at the lane reads, then at the merge; one per cycle if no stall.
// Lane banks give one registered read per cycle, which sets the first stage.
// SLOTS must be a power of two, which the block does not check; at most SLOTS-1 bytes are held.
// Synchronous reset zeroes both pointers and empties the pipeline; the byte
// store itself is not cleared. Depends on brb_pkg, brb_lane and brb_merge.
`default_nettype none

module byte_ring_buffer_core #(
  parameter int SLOTS = brb_pkg::SLOTS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           mode,
  input  wire logic [3:0]           byte_count,
  input  wire logic [63:0]          push_bytes,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      ok,
  output logic [63:0]               read_bytes,
  output logic [brb_pkg::COUNT_W-1:0] stored_count,
  output logic [brb_pkg::COUNT_W-1:0] free_count,
  output logic                      is_empty,
  output logic                      is_full
);

  localparam int PW = $clog2(SLOTS);
  localparam int ROW_W = PW - brb_pkg::LANE_W;
  localparam int ROWS = SLOTS / brb_pkg::LANES;

  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [PW-1:0] read_pointer, read_pointer_next;
  logic          accept, take, a_valid;
  logic [PW-1:0] held, room, cnt_ext, held_next, room_next;
  logic          fits, op_ok, op_show, push_ok;
  brb_pkg::meta_t       a_meta, meta_next;
  brb_pkg::lane_bytes_t lane_data;

  assign in_stall = a_valid && !take;
  assign accept = in_valid && !in_stall;

  assign held = write_pointer - read_pointer;
  assign room = PW'(SLOTS - 1) - held;
  assign cnt_ext = PW'(byte_count);
  assign fits = byte_count <= brb_pkg::BYTE_COUNT_W'(brb_pkg::MAX_BYTES_PER_ITEM);

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next = read_pointer;
    op_ok = 1'b0;
    op_show = 1'b0;
    push_ok = 1'b0;
    unique case (brb_pkg::mode_t'(mode))
      brb_pkg::MODE_PUSH: begin
        if (fits && room >= cnt_ext) begin
          op_ok = 1'b1;
          push_ok = 1'b1;
          write_pointer_next = write_pointer + cnt_ext;
        end
      end
      brb_pkg::MODE_POP: begin
        if (fits && held >= cnt_ext) begin
          op_ok = 1'b1;
          op_show = 1'b1;
          read_pointer_next = read_pointer + cnt_ext;
        end
      end
      brb_pkg::MODE_PEEK: begin
        if (fits && held >= cnt_ext) begin
          op_ok = 1'b1;
          op_show = 1'b1;
        end
      end
      brb_pkg::MODE_DISCARD: begin
        if (fits && held >= cnt_ext) begin
          op_ok = 1'b1;
          read_pointer_next = read_pointer + cnt_ext;
        end
      end
      brb_pkg::MODE_CLEAR: begin
        op_ok = 1'b1;
        write_pointer_next = '0;
        read_pointer_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign held_next = write_pointer_next - read_pointer_next;
  assign room_next = PW'(SLOTS - 1) - held_next;

  always_comb begin
    meta_next.ok = op_ok;
    meta_next.show = op_show;
    meta_next.count = byte_count;
    meta_next.rot = read_pointer[brb_pkg::LANE_W-1:0];
    meta_next.stored = brb_pkg::COUNT_W'(held_next);
    meta_next.free = brb_pkg::COUNT_W'(room_next);
    meta_next.empty = held_next == '0;
    meta_next.full = room_next == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer <= '0;
      a_valid <= 1'b0;
    end else begin
      if (accept) begin
        write_pointer <= write_pointer_next;
        read_pointer <= read_pointer_next;
        a_valid <= 1'b1;
      end else if (take) begin
        a_valid <= 1'b0;
      end
    end
    if (accept) begin
      a_meta <= meta_next;
    end
  end

  for (genvar l = 0; l < brb_pkg::LANES; l++) begin : g_lane
    logic [brb_pkg::LANE_W-1:0] wr_off, rd_off;
    logic [PW-1:0]              wr_addr, rd_addr;
    logic                       wr_en;

    assign wr_off = brb_pkg::LANE_W'(l) - write_pointer[brb_pkg::LANE_W-1:0];
    assign rd_off = brb_pkg::LANE_W'(l) - read_pointer[brb_pkg::LANE_W-1:0];
    assign wr_addr = write_pointer + PW'(wr_off);
    assign rd_addr = read_pointer + PW'(rd_off);
    assign wr_en = accept && push_ok && (brb_pkg::BYTE_COUNT_W'(wr_off) < byte_count);

    brb_lane #(
      .ROWS (ROWS),
      .ROW_W(ROW_W)
    ) u_lane (
      .clk    (clk),
      .wr_en  (wr_en),
      .wr_row (wr_addr[PW-1:brb_pkg::LANE_W]),
      .wr_data(push_bytes[8*wr_off +: 8]),
      .rd_en  (accept && op_show),
      .rd_row (rd_addr[PW-1:brb_pkg::LANE_W]),
      .rd_data(lane_data[l])
    );
  end

  brb_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .a_valid     (a_valid),
    .a_meta      (a_meta),
    .lane_data   (lane_data),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .read_bytes  (read_bytes),
    .stored_count(stored_count),
    .free_count  (free_count),
    .is_empty    (is_empty),
    .is_full     (is_full)
  );

endmodule

`default_nettype wire

>>> tb/tb_byte_ring_buffer_core.sv
// Self-checking testbench for byte_ring_buffer_core: directed and random beats
// checked against a cycle-free model of the byte ring held in a scoreboard class.
// Depends on brb_pkg and byte_ring_buffer_core.
module tb_byte_ring_buffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS = brb_pkg::SLOTS_DEFAULT;
  localparam int PHASE_BEATS = 250;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic                        ok;
    logic [63:0]                 data;
    logic [brb_pkg::COUNT_W-1:0] stored;
    logic [brb_pkg::COUNT_W-1:0] free;
    logic                        empty;
    logic                        full;
  } ring_status_t;

  class ring_scoreboard;
    logic [7:0] ring [RING_SLOTS];
    int wr_ptr;
    int rd_ptr;
    ring_status_t expected_q[$];
    int fails;
    int beats;
    int refusals;
    int full_ends;
    int empty_ends;
    int wraps;

    function new();
      wr_ptr = 0;
      rd_ptr = 0;
      fails = 0;
      beats = 0;
      refusals = 0;
      full_ends = 0;
      empty_ends = 0;
      wraps = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report_mismatch(input string what, input logic [63:0] got,
                         input logic [63:0] want);
      $display("MISMATCH %s: got %h, expected %h", what, got, want);
      fails++;
    endtask

    function void note_input(input logic [2:0] m, input logic [3:0] c,
                             input logic [63:0] d);
      int held;
      int room;
      int n;
      ring_status_t st;
      held = (wr_ptr + RING_SLOTS - rd_ptr) % RING_SLOTS;
      room = RING_SLOTS - 1 - held;
      n = int'(c);
      st = '0;
      case (m)
        brb_pkg::MODE_PUSH: begin
          if (n <= brb_pkg::MAX_BYTES_PER_ITEM && room >= n) begin
            for (int i = 0; i < n; i++) begin
              ring[wr_ptr] = d[8*i +: 8];
              wr_ptr = (wr_ptr + 1) % RING_SLOTS;
              if (wr_ptr == 0) wraps++;
            end
            st.ok = 1'b1;
          end
        end
        brb_pkg::MODE_POP, brb_pkg::MODE_PEEK, brb_pkg::MODE_DISCARD: begin
          if (n <= brb_pkg::MAX_BYTES_PER_ITEM && held >= n) begin
            if (m != brb_pkg::MODE_DISCARD) begin
              for (int i = 0; i < n; i++) begin
                st.data[8*i +: 8] = ring[(rd_ptr + i) % RING_SLOTS];
              end
            end
            if (m != brb_pkg::MODE_PEEK) rd_ptr = (rd_ptr + n) % RING_SLOTS;
            st.ok = 1'b1;
          end
        end
        brb_pkg::MODE_CLEAR: begin
          wr_ptr = 0;
          rd_ptr = 0;
          st.ok = 1'b1;
        end
        default: begin
        end
      endcase
      held = (wr_ptr + RING_SLOTS - rd_ptr) % RING_SLOTS;
      room = RING_SLOTS - 1 - held;
      st.stored = held[brb_pkg::COUNT_W-1:0];
      st.free = room[brb_pkg::COUNT_W-1:0];
      st.empty = (held == 0);
      st.full = (room == 0);
      beats++;
      if (!st.ok) refusals++;
      if (st.full) full_ends++;
      if (st.empty) empty_ends++;
      expected_q.push_back(st);
    endfunction

    task check_result(input logic g_ok, input logic [63:0] g_data,
                      input logic [brb_pkg::COUNT_W-1:0] g_stored,
                      input logic [brb_pkg::COUNT_W-1:0] g_free,
                      input logic g_empty, input logic g_full);
      ring_status_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing expected", g_data, '0);
      end else begin
        want = expected_q.pop_front();
        if (g_ok !== want.ok) report_mismatch("ok", 64'(g_ok), 64'(want.ok));
        if (g_data !== want.data) report_mismatch("read_bytes", g_data, want.data);
        if (g_stored !== want.stored) begin
          report_mismatch("stored_count", 64'(g_stored), 64'(want.stored));
        end
        if (g_free !== want.free) begin
          report_mismatch("free_count", 64'(g_free), 64'(want.free));
        end
        if (g_empty !== want.empty) begin
          report_mismatch("is_empty", 64'(g_empty), 64'(want.empty));
        end
        if (g_full !== want.full) begin
          report_mismatch("is_full", 64'(g_full), 64'(want.full));
        end
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [2:0] mode;
  logic [3:0] byte_count;
  logic [63:0] push_bytes;
  logic out_valid;
  logic out_stall;
  logic ok;
  logic [63:0] read_bytes;
  logic [brb_pkg::COUNT_W-1:0] stored_count;
  logic [brb_pkg::COUNT_W-1:0] free_count;
  logic is_empty;
  logic is_full;

  ring_scoreboard sb;
  bit hold_req;

  byte_ring_buffer_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .byte_count(byte_count),
    .push_bytes(push_bytes),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ok(ok),
    .read_bytes(read_bytes),
    .stored_count(stored_count),
    .free_count(free_count),
    .is_empty(is_empty),
    .is_full(is_full)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_input(mode, byte_count, push_bytes);
      if (out_valid && !out_stall) begin
        sb.check_result(ok, read_bytes, stored_count, free_count, is_empty, is_full);
      end
    end
  end

  task automatic send_beat(input logic [2:0] m, input logic [3:0] c, input logic [63:0] d);
    in_valid <= 1'b1;
    mode <= m;
    byte_count <= c;
    push_bytes <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int lvl;
    int n;
    int r;
    out_stall = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        lvl = 1;
        n = HOLD_CYCLES;
      end else begin
        r = $urandom_range(99);
        if (r < 45) begin
          lvl = 0;
          n = $urandom_range(4, 1);
        end else if (r < 60) begin
          lvl = 0;
          n = $urandom_range(60, 20);
        end else if (r < 92) begin
          lvl = 1;
          n = $urandom_range(3, 1);
        end else begin
          lvl = 1;
          n = $urandom_range(30, 8);
        end
      end
      out_stall <= lvl[0];
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    logic [2:0] m;
    logic [3:0] c;
    logic [63:0] d;
    bit filling;
    int r;
    int gap;
    sb = new();
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = '0;
    byte_count = '0;
    push_bytes = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_beat(brb_pkg::MODE_POP, 4'd0, '0);
    send_beat(brb_pkg::MODE_POP, 4'd1, '0);
    send_beat(brb_pkg::MODE_PEEK, 4'd1, '0);
    send_beat(brb_pkg::MODE_DISCARD, 4'd1, '0);
    send_beat(brb_pkg::MODE_PUSH, 4'd0, '1);
    send_beat(brb_pkg::MODE_PUSH, 4'd15, '1);
    send_beat(brb_pkg::MODE_PUSH, 4'd9, '1);
    send_beat(brb_pkg::MODE_PUSH, 4'd8, '1);
    send_beat(brb_pkg::MODE_PUSH, 4'd3, 64'hFFFF_FFFF_FFA5_5AC3);
    send_beat(brb_pkg::MODE_PEEK, 4'd9, '0);
    send_beat(brb_pkg::MODE_PEEK, 4'd8, '0);
    send_beat(brb_pkg::MODE_POP, 4'd8, '0);
    send_beat(brb_pkg::MODE_PEEK, 4'd3, '1);
    send_beat(brb_pkg::MODE_DISCARD, 4'd2, '0);
    send_beat(brb_pkg::MODE_POP, 4'd2, '0);
    send_beat(3'd5, 4'd1, '1);
    send_beat(3'd6, 4'd0, '0);
    send_beat(3'd7, 4'd15, '1);
    send_beat(brb_pkg::MODE_CLEAR, 4'd15, '1);
    send_beat(brb_pkg::MODE_PUSH, 4'd8, '0);
    send_beat(brb_pkg::MODE_DISCARD, 4'd0, '0);
    send_beat(brb_pkg::MODE_POP, 4'd8, '0);
    send_beat(brb_pkg::MODE_PUSH, 4'd8, {$urandom, $urandom});
    send_beat(brb_pkg::MODE_CLEAR, 4'd0, '0);
    drain_wait();

    // Even phases lean toward pushes to reach a full ring, odd ones drain it.
    for (int phase = 0; phase < 7; phase++) begin
      filling = (phase % 2 == 0);
      if (phase == 3) hold_req = 1'b1;
      if (phase == 5) drain_wait();
      for (int k = 0; k < PHASE_BEATS; k++) begin
        r = $urandom_range(99);
        if (!filling && r == 0) begin
          m = brb_pkg::MODE_CLEAR;
        end else if (r < 3) begin
          m = 3'($urandom_range(7, 5));
        end else if (r < (filling ? 78 : 23)) begin
          m = brb_pkg::MODE_PUSH;
        end else begin
          r = $urandom_range(3);
          m = (r < 2) ? brb_pkg::MODE_POP :
              ((r == 2) ? brb_pkg::MODE_PEEK : brb_pkg::MODE_DISCARD);
        end
        r = $urandom_range(99);
        if (r < 8) c = 4'($urandom_range(15, 9));
        else if (r < 50) c = 4'd8;
        else c = 4'($urandom_range(8, 0));
        d = {$urandom, $urandom};

        r = $urandom_range(99);
        if (phase == 3 && k < 100) gap = 0;
        else if (r < 55) gap = 0;
        else if (r < 85) gap = $urandom_range(3, 1);
        else if (r < 97) gap = $urandom_range(10, 4);
        else gap = $urandom_range(30, 15);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        send_beat(m, c, d);
      end
    end

    drain_wait();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.report_mismatch("result beats never arrived", '0, 64'(sb.pending()));
    end
    $display("Checked %0d beats: %0d refused, %0d left the ring full, %0d left it empty.",
             sb.beats, sb.refusals, sb.full_ends, sb.empty_ends);
    $display("The write pointer wrapped %0d times; %0d mismatches.", sb.wraps, sb.fails);
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
